@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define SLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SLI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/sli_pkg.sv @@
// Package with types and constants of the lateral inhibition block.
package sli_pkg;

  localparam int GRID_WIDTH       = 8;
  localparam int GRID_HEIGHT      = 8;
  localparam int NEIGHBOUR_RADIUS = 2;

  localparam int NEURONS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int SPAN     = 2 * NEIGHBOUR_RADIUS + 1;
  localparam int SLOTS    = SPAN * SPAN;
  localparam int NEURON_W = 6;
  localparam int SLOT_W   = 5;
  localparam int WADDR_W  = $clog2(NEURONS * SLOTS);
  localparam int INHIB_W  = 16 + $clog2(SLOTS) + 1;
  localparam int SUM_W    = INHIB_W + 2;
  localparam int ITER_W   = 8;
  localparam int CNT_W    = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_EXC = 2'd0,
    OP_THR = 2'd1,
    OP_WGT = 2'd2,
    OP_RUN = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLE  = 2'd0,
    CFG_MEASURE = 2'd1,
    CFG_LEAK    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_ACC,
    ST_MUL,
    ST_WB,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         neuron_index;
    logic [4:0]         neighbour_offset;
    logic signed [15:0] value;
  } item_t;

  typedef struct packed {
    logic [5:0] result_neuron;
    logic [7:0] spike_count;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [ITER_W-1:0] settle_iterations;
    logic [ITER_W-1:0] measure_iterations;
    logic [15:0]       leak_factor;
  } cfg_t;

endpackage

@@ hw/rtl/sli_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module sli_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sli_engine.sv @@
// Sequencer and datapath that run the neuron iterations over the stores.
module sli_engine import sli_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output logic    busy,
  output logic    result_valid_o,
  output result_t result_o
);

  state_e state_q, state_d;

  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [NEURON_W-1:0] n_q, n_d, out_n_q, out_n_d;
  logic [NEURON_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [3:0]   dx_q, dx_d, dy_q, dy_d;
  logic [WADDR_W-1:0]  waddr_q, waddr_d;
  logic [ITER_W-1:0]   iter_q, iter_d;
  logic                meas_q, meas_d, first_iter_q, first_iter_d;
  logic                first_meas_q, first_meas_d, counted_q, counted_d;
  logic                use_q, use_d, out_vld_q, out_vld_d;
  logic [NEURONS-1:0]  spk_before_q, spk_before_d, spk_now_q, spk_now_d;
  logic signed [INHIB_W-1:0] inhib_q, inhib_d;
  logic signed [33:0]  prod_q, prod_d;

  logic                accept, run, last_n, last_slot, iter_last;
  logic [ITER_W-1:0]   iter_limit;

  logic signed [7:0]   nx, ny;
  logic [11:0]         k;
  logic                in_grid;

  logic                wgt_we, exc_we, thr_we, act_we, cnt_we;
  logic [WADDR_W-1:0]  wgt_waddr;
  logic [NEURON_W-1:0] nrn_waddr;
  logic [15:0]         wgt_wdata, nrn_wdata, act_wdata;
  logic [CNT_W-1:0]    cnt_wdata;
  logic                nrn_re;
  logic [NEURON_W-1:0] cnt_raddr;
  logic [15:0]         wgt_rdata, exc_rdata, thr_rdata, act_rdata;
  logic [CNT_W-1:0]    cnt_rdata, cnt_old;

  logic signed [15:0]  act_in;
  logic signed [SUM_W-1:0] sum;
  logic signed [15:0]  sat;
  logic                fire;
  logic [16:0]         keep;
  logic [11:0]         load_waddr;

  assign accept    = start && !busy;
  assign run       = accept && (item_i.operation == OP_RUN);
  assign last_n    = (n_q == NEURON_W'(NEURONS - 1));
  assign last_slot = (slot_q == SLOT_W'(SLOTS - 1));
  assign iter_limit = meas_q ? cfg_i.measure_iterations : cfg_i.settle_iterations;
  assign iter_last = (iter_q == iter_limit - ITER_W'(1));
  assign keep      = 17'd65536 - {1'b0, cfg_i.leak_factor};

  assign nx = $signed({2'b00, x_q}) + 8'(dx_q);
  assign ny = $signed({2'b00, y_q}) + 8'(dy_q);
  assign in_grid = (nx >= 0) && (nx < 8'(GRID_WIDTH)) && (ny >= 0) && (ny < 8'(GRID_HEIGHT));
  assign k = 12'(ny[6:0] * GRID_WIDTH) + 12'(nx[6:0]);
  assign load_waddr = 12'(item_i.neuron_index * SLOTS) + 12'(item_i.neighbour_offset);

  assign act_in = first_iter_q ? 16'sd0 : $signed(act_rdata);
  assign sum = SUM_W'(prod_q >>> 16) + SUM_W'($signed(exc_rdata)) + SUM_W'(inhib_q);
  always_comb begin
    if (sum > SUM_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (sum < -SUM_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end
  assign fire = sat > $signed(thr_rdata);
  assign cnt_old = first_meas_q ? '0 : cnt_rdata;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (waddr_q == WADDR_W'(NEURONS * SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (run) begin
          if (cfg_i.settle_iterations != '0 || cfg_i.measure_iterations != '0) begin
            state_d = ST_ISSUE;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_ISSUE: begin
        if (last_slot) state_d = ST_ACC;
      end
      ST_ACC: state_d = ST_MUL;
      ST_MUL: state_d = ST_WB;
      ST_WB: begin
        if (!last_n) begin
          state_d = ST_ISSUE;
        end else if (iter_last && (meas_q || cfg_i.measure_iterations == '0)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_ISSUE;
        end
      end
      ST_OUT: begin
        if (last_n) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    slot_d = slot_q;       n_d = n_q;         x_d = x_q;       y_d = y_q;
    dx_d = dx_q;           dy_d = dy_q;       waddr_d = waddr_q;
    iter_d = iter_q;       meas_d = meas_q;   first_iter_d = first_iter_q;
    first_meas_d = first_meas_q;              counted_d = counted_q;
    use_d = 1'b0;          out_vld_d = 1'b0;  out_n_d = out_n_q;
    spk_before_d = spk_before_q;              spk_now_d = spk_now_q;
    inhib_d = inhib_q;     prod_d = prod_q;
    wgt_we = 1'b0; exc_we = 1'b0; thr_we = 1'b0; act_we = 1'b0; cnt_we = 1'b0;
    wgt_waddr = waddr_q;   nrn_waddr = n_q;
    wgt_wdata = '0;        nrn_wdata = '0;
    act_wdata = sat;       cnt_wdata = cnt_old;
    nrn_re = 1'b0;         cnt_raddr = n_q;
    unique case (state_q)
      ST_CLEAR: begin
        wgt_we = 1'b1;
        if (waddr_q < WADDR_W'(NEURONS)) begin
          exc_we = 1'b1;
          thr_we = 1'b1;
          nrn_waddr = waddr_q[NEURON_W-1:0];
        end
        waddr_d = waddr_q + WADDR_W'(1);
      end
      ST_IDLE: begin
        nrn_waddr = item_i.neuron_index;
        nrn_wdata = item_i.value;
        wgt_wdata = item_i.value;
        wgt_waddr = load_waddr[WADDR_W-1:0];
        if (accept && ({1'b0, item_i.neuron_index} < (NEURON_W + 1)'(NEURONS))) begin
          exc_we = (item_i.operation == OP_EXC);
          thr_we = (item_i.operation == OP_THR);
          wgt_we = (item_i.operation == OP_WGT) &&
                   (item_i.neighbour_offset < SLOT_W'(SLOTS));
        end
        if (run) begin
          slot_d = '0; n_d = '0; x_d = '0; y_d = '0; waddr_d = '0; iter_d = '0;
          dx_d = -4'(NEIGHBOUR_RADIUS); dy_d = -4'(NEIGHBOUR_RADIUS);
          meas_d = (cfg_i.settle_iterations == '0);
          first_meas_d = 1'b1;
          first_iter_d = 1'b1;
          counted_d = (cfg_i.measure_iterations != '0);
          spk_before_d = '0;
          spk_now_d = '0;
        end
      end
      ST_ISSUE: begin
        nrn_re = (slot_q == '0);
        inhib_d = (slot_q == '0) ? '0 :
                  inhib_q - (use_q ? INHIB_W'($signed(wgt_rdata)) : INHIB_W'(0));
        use_d = in_grid && !(dx_q == 0 && dy_q == 0) && spk_before_q[k[NEURON_W-1:0]];
        waddr_d = waddr_q + WADDR_W'(1);
        if (last_slot) begin
          slot_d = '0;
          dx_d = -4'(NEIGHBOUR_RADIUS);
          dy_d = -4'(NEIGHBOUR_RADIUS);
        end else begin
          slot_d = slot_q + SLOT_W'(1);
          if (dx_q == 4'(NEIGHBOUR_RADIUS)) begin
            dx_d = -4'(NEIGHBOUR_RADIUS);
            dy_d = dy_q + 4'sd1;
          end else begin
            dx_d = dx_q + 4'sd1;
          end
        end
      end
      ST_ACC: begin
        inhib_d = inhib_q - (use_q ? INHIB_W'($signed(wgt_rdata)) : INHIB_W'(0));
      end
      ST_MUL: begin
        prod_d = 34'(act_in) * $signed({1'b0, keep});
      end
      ST_WB: begin
        act_we = 1'b1;
        act_wdata = fire ? 16'd0 : sat;
        cnt_we = meas_q;
        cnt_wdata = (fire && cnt_old != '1) ? cnt_old + CNT_W'(1) : cnt_old;
        spk_now_d[n_q] = fire;
        n_d = n_q + NEURON_W'(1);
        if (x_q == NEURON_W'(GRID_WIDTH - 1)) begin
          x_d = '0;
          y_d = y_q + NEURON_W'(1);
        end else begin
          x_d = x_q + NEURON_W'(1);
        end
        if (last_n) begin
          n_d = '0; x_d = '0; y_d = '0; waddr_d = '0;
          spk_before_d = spk_now_q;
          spk_before_d[n_q] = fire;
          spk_now_d = '0;
          first_iter_d = 1'b0;
          if (meas_q) first_meas_d = 1'b0;
          if (iter_last && !meas_q) begin
            meas_d = 1'b1;
            iter_d = '0;
          end else begin
            iter_d = iter_q + ITER_W'(1);
          end
        end
      end
      ST_OUT: begin
        cnt_raddr = n_q;
        nrn_re = 1'b1;
        out_vld_d = 1'b1;
        out_n_d = n_q;
        n_d = n_q + NEURON_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      waddr_q      <= '0;
      out_vld_q    <= 1'b0;
      use_q        <= 1'b0;
      slot_q       <= '0;
      n_q          <= '0;
      iter_q       <= '0;
      meas_q       <= 1'b0;
      first_iter_q <= 1'b1;
      first_meas_q <= 1'b1;
      counted_q    <= 1'b0;
      spk_before_q <= '0;
      spk_now_q    <= '0;
    end else begin
      state_q      <= state_d;
      waddr_q      <= waddr_d;
      out_vld_q    <= out_vld_d;
      use_q        <= use_d;
      slot_q       <= slot_d;
      n_q          <= n_d;
      iter_q       <= iter_d;
      meas_q       <= meas_d;
      first_iter_q <= first_iter_d;
      first_meas_q <= first_meas_d;
      counted_q    <= counted_d;
      spk_before_q <= spk_before_d;
      spk_now_q    <= spk_now_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    inhib_q <= inhib_d;
    prod_q  <= prod_d;
    out_n_q <= out_n_d;
  end

  sli_ram #(.Width(16), .Depth(NEURONS * SLOTS)) u_wgt_ram (
    .clk_i, .we_i(wgt_we), .waddr_i(wgt_waddr), .wdata_i(wgt_wdata),
    .re_i(state_q == ST_ISSUE), .raddr_i(waddr_q), .rdata_o(wgt_rdata)
  );
  sli_ram #(.Width(16), .Depth(NEURONS)) u_exc_ram (
    .clk_i, .we_i(exc_we), .waddr_i(nrn_waddr), .wdata_i(nrn_wdata),
    .re_i(nrn_re), .raddr_i(n_q), .rdata_o(exc_rdata)
  );
  sli_ram #(.Width(16), .Depth(NEURONS)) u_thr_ram (
    .clk_i, .we_i(thr_we), .waddr_i(nrn_waddr), .wdata_i(nrn_wdata),
    .re_i(nrn_re), .raddr_i(n_q), .rdata_o(thr_rdata)
  );
  sli_ram #(.Width(16), .Depth(NEURONS)) u_act_ram (
    .clk_i, .we_i(act_we), .waddr_i(n_q), .wdata_i(act_wdata),
    .re_i(nrn_re), .raddr_i(n_q), .rdata_o(act_rdata)
  );
  sli_ram #(.Width(CNT_W), .Depth(NEURONS)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(n_q), .wdata_i(cnt_wdata),
    .re_i(nrn_re), .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  assign busy = (state_q != ST_IDLE) || out_vld_q;
  assign result_valid_o = out_vld_q;
  assign result_o.result_neuron = out_n_q;
  assign result_o.spike_count = counted_q ? cnt_rdata : '0;
  assign result_o.last_result = out_vld_q && (out_n_q == NEURON_W'(NEURONS - 1));

endmodule

@@ hw/rtl/spiking_lateral_inhibition_top.sv @@
// Top level of the lateral inhibition block: configuration registers and engine.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------
//   input    | start high, busy low      | item_i
//   result   | result_valid_o, one cycle | result_o
//   config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A run reads the weight memory once per neighbour slot in ST_ISSUE, then
// passes each neuron through ST_ACC, ST_MUL and ST_WB. After reset a clearing
// pass over the 1600 weight entries keeps busy high. Results cannot be stalled.
`include "assert_macros.svh"
module spiking_lateral_inhibition_top import sli_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SETTLE:  cfg_d.settle_iterations  = cfg_wdata_i[ITER_W-1:0];
        CFG_MEASURE: cfg_d.measure_iterations = cfg_wdata_i[ITER_W-1:0];
        CFG_LEAK:    cfg_d.leak_factor        = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_iterations  <= ITER_W'(4);
      cfg_q.measure_iterations <= ITER_W'(8);
      cfg_q.leak_factor        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sli_engine u_engine (
    .clk_i, .rst_ni, .start, .item_i, .cfg_i(cfg_q), .busy,
    .result_valid_o, .result_o
  );

  `SLI_ASSERT(a_result_busy, result_valid_o |-> busy, "result outside a busy period")
  `SLI_ASSERT(a_last_valid, result_o.last_result |-> result_valid_o, "last flag without result")
  `SLI_ASSERT(a_run_busy, (start && !busy && item_i.operation == OP_RUN) |=> busy,
              "run transaction did not raise busy")
  `SLI_NEVER(a_result_after_last, $past(result_o.last_result) && result_valid_o,
             "result after the last one of a run")

endmodule
